// File: rtl/imu_cf_pkg.sv
// ----------------------------------------------------------------------------
// imu_cf_pkg
// Shared widths, sequencer states, register codes, the CORDIC angle table
// and the saturation helper of the attitude filter.
// ----------------------------------------------------------------------------
package imu_cf_pkg;

  localparam int unsigned CORDIC_STEPS = 16;  // range 8 to 32
  localparam int unsigned CordicCntW   = $clog2(CORDIC_STEPS);
  localparam int unsigned MsPerS       = 1000;

  localparam int unsigned SqW    = 32;  // sum of two squares
  localparam int unsigned RadW   = 48;  // radicand, sum shifted by 16
  localparam int unsigned RootW  = 24;
  localparam int unsigned CorW   = 28;  // cordic x and y
  localparam int unsigned YInW   = 25;  // numerator times 256
  localparam int unsigned AngW   = 32;
  localparam int unsigned NumW   = 56;  // divider dividend
  localparam int unsigned DenW   = 26;  // sensitivity times 1000
  localparam int unsigned MulAW  = 18;
  localparam int unsigned MulBW  = 33;
  localparam int unsigned MulPW  = 51;

  localparam logic [1:0] RegSens  = 2'd0;
  localparam logic [1:0] RegGyroW = 2'd1;
  localparam logic [1:0] RegAccW  = 2'd2;

  localparam logic [1:0] AxisRoll  = 2'd0;
  localparam logic [1:0] AxisPitch = 2'd1;
  localparam logic [1:0] AxisYaw   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_ROT_WAIT,
    ST_DEN,
    ST_DEN_CAP,
    ST_PROD,
    ST_PROD_CAP,
    ST_DIV_WAIT,
    ST_BL_GYRO,
    ST_BL_TILT,
    ST_BL_SUM,
    ST_DONE
  } state_e;

  // atan(2^-i) in q15.16 degrees
  function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AngW-1:0] sat32(input logic signed [63:0] v);
    logic signed [AngW-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[AngW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/imu_cf_mul.sv
// ----------------------------------------------------------------------------
// imu_cf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module imu_cf_mul (
  input  logic                                 clk_i,
  input  logic signed [imu_cf_pkg::MulAW-1:0]  a_i,
  input  logic signed [imu_cf_pkg::MulBW-1:0]  b_i,
  output logic signed [imu_cf_pkg::MulPW-1:0]  p_o
);
  import imu_cf_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/imu_cf_sqrt.sv
// ----------------------------------------------------------------------------
// imu_cf_sqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module imu_cf_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [imu_cf_pkg::RadW-1:0]        rad_i,
  output logic                               done_o,
  output logic [imu_cf_pkg::RootW-1:0]       root_o
);
  import imu_cf_pkg::*;

  localparam int unsigned RemW = RootW + 3;

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_t, trial;

  assign rem_t = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/imu_cf_cordic.sv
// ----------------------------------------------------------------------------
// imu_cf_cordic
// Vectoring cordic, one rotation per cycle, angle in q15.16 degrees.
// ----------------------------------------------------------------------------
module imu_cf_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [imu_cf_pkg::RootW-1:0]        x_i,
  input  logic signed [imu_cf_pkg::YInW-1:0]  y_i,
  output logic                                done_o,
  output logic signed [imu_cf_pkg::AngW-1:0]  z_o
);
  import imu_cf_pkg::*;

  logic                    busy_q, done_q;
  logic [CordicCntW-1:0]   cnt_q;
  logic signed [CorW-1:0]  x_q, y_q, xs, ys;
  logic signed [AngW-1:0]  z_q, ang;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = atan_deg(5'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CordicCntW'(1);
        if (cnt_q == CordicCntW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= $signed(CorW'(x_i));
      y_q <= CorW'(y_i);
      z_q <= '0;
    end else if (busy_q) begin
      if (!y_q[CorW-1] && (y_q != '0)) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else if (y_q[CorW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

// File: rtl/imu_cf_div.sv
// ----------------------------------------------------------------------------
// imu_cf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imu_cf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [imu_cf_pkg::NumW-1:0]   num_i,
  input  logic [imu_cf_pkg::DenW-1:0]   den_i,
  output logic                          done_o,
  output logic [imu_cf_pkg::NumW-1:0]   quo_o
);
  import imu_cf_pkg::*;

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [NumW-1:0] nq_q;
  logic [DenW-1:0] den_q, rem_q;
  logic [DenW:0]   rem_t;

  assign rem_t = {rem_q, nq_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_t >= {1'b0, den_q}) begin
        rem_q <= DenW'(rem_t - {1'b0, den_q});
        nq_q  <= {nq_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_t[DenW-1:0];
        nq_q  <= {nq_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

// File: rtl/imu_complementary_attitude_filter_core.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_core
// Complementary roll, pitch and yaw filter for one six-axis imu sample per
// item, built around a shared multiplier, square root, cordic and divider.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) takes one sample item: three
//   accelerometer axes, three gyro rates and the milliseconds since the
//   previous sample. output channel (out_valid_o / out_ready_i) returns one
//   item with roll, pitch and yaw in signed q15.16 degrees.
//   an item's time is set mostly by the three bit-serial 56-bit divisions
//   (one per gyro axis); a tilt whose root is zero skips the square root
//   and cordic. one item is worked on at a time, and in_ready_o is high
//   only while the sequencer is idle.
//   the result sits in an output register; a stalled receiver holds the
//   sequencer in its final state until that register is free, so nothing
//   is lost. the next item may be taken while a result waits.
//   reset clears the kept angles and loads the default sensitivity (131 lsb per
//   deg/s) and weights (0.96 gyro, 0.04 accel). the user must write the apb
//   port only while idle; the block does not enforce it. pready is always high.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // sample items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [15:0]                  accel_x_i,
  input  logic signed [15:0]                  accel_y_i,
  input  logic signed [15:0]                  accel_z_i,
  input  logic signed [15:0]                  rate_x_i,
  input  logic signed [15:0]                  rate_y_i,
  input  logic signed [15:0]                  rate_z_i,
  input  logic [15:0]                         elapsed_ms_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [imu_cf_pkg::AngW-1:0]  roll_deg_o,
  output logic signed [imu_cf_pkg::AngW-1:0]  pitch_deg_o,
  output logic signed [imu_cf_pkg::AngW-1:0]  yaw_deg_o
);
  import imu_cf_pkg::*;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] sens_q, gyro_w_q, acc_w_q;

  // captured sample
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic [15:0]        ms_q;

  // sequencer bookkeeping
  logic [1:0] axis_q, cnt_q;

  // working values
  logic [SqW-1:0]          sq_x_q, sq_y_q, sq_z_q;
  logic signed [AngW-1:0]  tilt_roll_q, tilt_pitch_q;
  logic [DenW-1:0]         den_q;
  logic signed [AngW-1:0]  g_roll_q, g_pitch_q;
  logic signed [MulPW-1:0] acc_q;

  // kept angles
  logic signed [AngW-1:0]  roll_q, pitch_q, yaw_q;

  // output register
  logic                    out_valid_q;
  logic signed [AngW-1:0]  out_roll_q, out_pitch_q, out_yaw_q;

  // shared units
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic                    sqrt_start, sqrt_done;
  logic [RootW-1:0]        root;
  logic                    cor_start, cor_done;
  logic signed [YInW-1:0]  cor_y;
  logic signed [AngW-1:0]  cor_z;
  logic                    div_start, div_done;
  logic [NumW-1:0]         div_num, div_quo;

  // combinational helpers
  logic [SqW-1:0]          root_sum;
  logic signed [16:0]      tilt_num;
  logic signed [15:0]      rate_sel;
  logic                    rate_neg;
  logic [16:0]             rate_mag;
  logic signed [AngW-1:0]  angle_sel, g_sel, tilt_sel;
  logic signed [NumW:0]    delta;
  logic signed [NumW+1:0]  gyro_sum;
  logic signed [AngW-1:0]  gyro_sat;
  logic signed [MulPW:0]   blend_sum;
  logic signed [AngW-1:0]  blend_sat;
  logic                    out_free;
  logic                    cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q   <= 16'd33536;
      gyro_w_q <= 16'd62915;
      acc_w_q  <= 16'd2621;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSens:  sens_q   <= pwdata[15:0];
        RegGyroW: gyro_w_q <= pwdata[15:0];
        RegAccW:  acc_w_q  <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSens:  prdata = {16'd0, sens_q};
      RegGyroW: prdata = {16'd0, gyro_w_q};
      RegAccW:  prdata = {16'd0, acc_w_q};
      default:  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared units
  // --------------------------------------------------------------------------
  imu_cf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  imu_cf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({root_sum, 16'd0}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  imu_cf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (root),
    .y_i     (cor_y),
    .done_o  (cor_done),
    .z_o     (cor_z)
  );

  imu_cf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // --------------------------------------------------------------------------
  // per-axis selection
  // --------------------------------------------------------------------------
  // roll tilt uses ay over sqrt(ax^2+az^2), pitch uses -ax over sqrt(ay^2+az^2)
  assign root_sum = (axis_q == AxisRoll) ? (sq_x_q + sq_z_q) : (sq_y_q + sq_z_q);
  assign tilt_num = (axis_q == AxisRoll) ? 17'(ay_q) : -17'(ax_q);
  assign cor_y    = {tilt_num, 8'd0};

  always_comb begin
    case (axis_q)
      AxisRoll:  begin rate_sel = gx_q; angle_sel = roll_q;  end
      AxisPitch: begin rate_sel = gy_q; angle_sel = pitch_q; end
      default:   begin rate_sel = gz_q; angle_sel = yaw_q;   end
    endcase
  end

  assign rate_neg = rate_sel[15];
  assign rate_mag = rate_neg ? 17'(-17'(rate_sel)) : 17'(rate_sel);

  // dividend is |rate|*ms*2^24 plus half the divisor for rounding
  assign div_num = {mul_p[31:0], 24'd0} + NumW'(den_q >> 1);

  assign delta    = rate_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign gyro_sum = (NumW+2)'(angle_sel) + (NumW+2)'(delta);
  assign gyro_sat = sat32(64'(gyro_sum));

  assign g_sel    = (axis_q == AxisRoll) ? g_roll_q : g_pitch_q;
  assign tilt_sel = (axis_q == AxisRoll) ? tilt_roll_q : tilt_pitch_q;

  // weighted sum, round half up, drop 16 fraction bits
  assign blend_sum = (MulPW+1)'(acc_q) + (MulPW+1)'(mul_p) + (MulPW+1)'(32768);
  assign blend_sat = sat32(64'(blend_sum >>> 16));

  assign out_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE:    if (cnt_q == 2'd3) state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_sum != '0) begin
          state_d = ST_ROOT_WAIT;
        end else if (axis_q == AxisPitch) begin
          state_d = ST_DEN;
        end
      end
      ST_ROOT_WAIT: if (sqrt_done) state_d = ST_ROT_WAIT;
      ST_ROT_WAIT: begin
        if (cor_done) state_d = (axis_q == AxisPitch) ? ST_DEN : ST_ROOT;
      end
      ST_DEN:       state_d = ST_DEN_CAP;
      ST_DEN_CAP:   state_d = ST_PROD;
      ST_PROD:      state_d = ST_PROD_CAP;
      ST_PROD_CAP:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_d = (axis_q == AxisYaw) ? ST_BL_GYRO : ST_PROD;
      end
      ST_BL_GYRO:   state_d = ST_BL_TILT;
      ST_BL_TILT:   state_d = ST_BL_SUM;
      ST_BL_SUM:    state_d = (axis_q == AxisPitch) ? ST_DONE : ST_BL_GYRO;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: unit controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    sqrt_start = 1'b0;
    cor_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SQUARE: begin
        case (cnt_q)
          2'd0:    begin mul_a = MulAW'(ax_q); mul_b = MulBW'(ax_q); end
          2'd1:    begin mul_a = MulAW'(ay_q); mul_b = MulBW'(ay_q); end
          default: begin mul_a = MulAW'(az_q); mul_b = MulBW'(az_q); end
        endcase
      end
      ST_ROOT:      sqrt_start = (root_sum != '0);
      ST_ROOT_WAIT: cor_start  = sqrt_done;
      ST_DEN: begin
        // zero sensitivity acts as one
        mul_a = $signed({2'b00, (sens_q == '0) ? 16'd1 : sens_q});
        mul_b = MulBW'(MsPerS);
      end
      ST_PROD: begin
        mul_a = $signed({1'b0, rate_mag});
        mul_b = $signed({17'd0, ms_q});
      end
      ST_PROD_CAP:  div_start = 1'b1;
      ST_BL_GYRO: begin
        mul_a = $signed({2'b00, gyro_w_q});
        mul_b = MulBW'(g_sel);
      end
      ST_BL_TILT: begin
        mul_a = $signed({2'b00, acc_w_q});
        mul_b = MulBW'(tilt_sel);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AxisRoll;
      cnt_q       <= '0;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          cnt_q  <= '0;
          axis_q <= AxisRoll;
        end
        ST_SQUARE: cnt_q <= cnt_q + 2'd1;
        ST_ROOT: begin
          if ((root_sum == '0) && (axis_q == AxisRoll)) axis_q <= AxisPitch;
        end
        ST_ROT_WAIT: begin
          if (cor_done && (axis_q == AxisRoll)) axis_q <= AxisPitch;
        end
        ST_DEN_CAP: axis_q <= AxisRoll;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (axis_q == AxisYaw) begin
              yaw_q  <= gyro_sat;
              axis_q <= AxisRoll;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        ST_BL_SUM: begin
          if (axis_q == AxisRoll) begin
            roll_q <= blend_sat;
            axis_q <= AxisPitch;
          end else begin
            pitch_q <= blend_sat;
          end
        end
        default: ;
      endcase
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // working registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ax_q <= accel_x_i;
          ay_q <= accel_y_i;
          az_q <= accel_z_i;
          gx_q <= rate_x_i;
          gy_q <= rate_y_i;
          gz_q <= rate_z_i;
          ms_q <= elapsed_ms_i;
        end
      end
      ST_SQUARE: begin
        case (cnt_q)
          2'd1:    sq_x_q <= mul_p[SqW-1:0];
          2'd2:    sq_y_q <= mul_p[SqW-1:0];
          2'd3:    sq_z_q <= mul_p[SqW-1:0];
          default: ;
        endcase
      end
      ST_ROOT: begin
        // both squares zero gives a level tilt
        if (root_sum == '0) begin
          if (axis_q == AxisRoll) tilt_roll_q <= '0;
          else                    tilt_pitch_q <= '0;
        end
      end
      ST_ROT_WAIT: begin
        if (cor_done) begin
          if (axis_q == AxisRoll) tilt_roll_q <= cor_z;
          else                    tilt_pitch_q <= cor_z;
        end
      end
      ST_DEN_CAP: den_q <= mul_p[DenW-1:0];
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (axis_q == AxisRoll)       g_roll_q  <= gyro_sat;
          else if (axis_q == AxisPitch) g_pitch_q <= gyro_sat;
        end
      end
      ST_BL_TILT: acc_q <= mul_p;
      ST_DONE: begin
        if (out_free) begin
          out_roll_q  <= roll_q;
          out_pitch_q <= pitch_q;
          out_yaw_q   <= yaw_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign roll_deg_o  = out_roll_q;
  assign pitch_deg_o = out_pitch_q;
  assign yaw_deg_o   = out_yaw_q;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complementary attitude filter: drives samples
// with random gaps, predicts roll, pitch and yaw in fixed point, and checks
// every result item in order through a small scoreboard.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imu_cf_pkg::*;

  // --------------------------------------------------------------------------
  // attitude predictor and expected-angle store
  // --------------------------------------------------------------------------
  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } attitude_t;

  class attitude_scoreboard;
    bit [15:0] sens = 16'd33536;
    bit [15:0] gyro_w = 16'd62915;
    bit [15:0] acc_w = 16'd2621;
    longint roll_q, pitch_q, yaw_q;
    attitude_t pending[$];
    int errors;

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint atan_step(int i);
      longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                        29, 14, 7, 4, 2, 1};
      return (i < 23) ? t[i] : 0;
    endfunction

    function longint int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // atan2(num, sqrt(a^2+b^2)) in q15.16 degrees by vectoring cordic
    function longint tilt_deg(longint num, longint a, longint b);
      longint unsigned sq;
      longint x, y, z, xs, ys;
      sq = a * a + b * b;
      if (sq == 0) return 0;
      x = int_root(sq << 16);
      y = num * 256;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_step(i);
        end else if (y < 0) begin
          x -= ys; y += xs; z -= atan_step(i);
        end
      end
      return z;
    endfunction

    function longint gyro_step(longint rate, longint unsigned ms);
      longint unsigned den, mag, q;
      den = ((sens == 0) ? 64'd1 : 64'(sens)) * 1000;
      mag = (rate < 0) ? -rate : rate;
      q = (((mag * ms) << 24) + den / 2) / den;
      return (rate < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint mix(longint g, longint t);
      longint s;
      s = longint'(gyro_w) * g + longint'(acc_w) * t + 32768;
      return clip32(s >>> 16);
    endfunction

    function void write_reg(logic [1:0] idx, bit [15:0] v);
      case (idx)
        RegSens:  sens = v;
        RegGyroW: gyro_w = v;
        RegAccW:  acc_w = v;
        default: ;
      endcase
    endfunction

    // note an accepted sample and queue its expected attitude
    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic signed [15:0] gx,
                              logic signed [15:0] gy, logic signed [15:0] gz,
                              logic [15:0] ms);
      longint rt, pt, rg, pg;
      attitude_t e;
      rt = tilt_deg(ay, ax, az);
      pt = tilt_deg(-longint'(ax), ay, az);
      rg = clip32(roll_q + gyro_step(gx, ms));
      pg = clip32(pitch_q + gyro_step(gy, ms));
      yaw_q = clip32(yaw_q + gyro_step(gz, ms));
      roll_q = mix(rg, rt);
      pitch_q = mix(pg, pt);
      e.roll = roll_q[31:0];
      e.pitch = pitch_q[31:0];
      e.yaw = yaw_q[31:0];
      pending.push_back(e);
    endfunction

    function void check_attitude(attitude_t got);
      attitude_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.roll !== e.roll) begin
        $error("roll_deg expected %0d actual %0d", e.roll, got.roll);
        errors++;
      end
      if (got.pitch !== e.pitch) begin
        $error("pitch_deg expected %0d actual %0d", e.pitch, got.pitch);
        errors++;
      end
      if (got.yaw !== e.yaw) begin
        $error("yaw_deg expected %0d actual %0d", e.yaw, got.yaw);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic [15:0] elapsed_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] roll_deg_o, pitch_deg_o, yaw_deg_o;

  imu_complementary_attitude_filter_core u_top (.*);

  attitude_scoreboard sb = new();

  // idle percentages, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;   // long receiver hold-off
  longint cycle_cnt = 0;

  // generous limit on the run length: every item plus stalls, many times over
  localparam longint CycleLimit = 64'd4_000_000;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("imu_complementary_attitude_filter_core regression: fail");
      $finish;
    end
  end

  // receiver: random ready, checks on handshake
  always @(posedge clk_i) begin
    attitude_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.roll = roll_deg_o;
        got.pitch = pitch_deg_o;
        got.yaw = yaw_deg_o;
        sb.check_attitude(got);
      end
      out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  // one write, then the bus returns to idle
  task automatic apb_write(logic [1:0] idx, bit [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays high across back-to-back items; it drops only for idle
  // cycles or in drain
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic signed [15:0] gx,
                             logic signed [15:0] gy, logic signed [15:0] gz,
                             logic [15:0] ms);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i <= ax; accel_y_i <= ay; accel_z_i <= az;
    rate_x_i <= gx; rate_y_i <= gy; rate_z_i <= gz;
    elapsed_ms_i <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(ax, ay, az, gx, gy, gz, ms);
  endtask

  // random sample; mostly small elapsed times so angles stay in range,
  // sometimes raw extremes to hit saturation
  task automatic send_random();
    logic [15:0] ms;
    case ($urandom_range(9))
      0: ms = 16'($urandom);
      1: ms = 16'd0;
      default: ms = 16'($urandom_range(1, 40));
    endcase
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), ms);
  endtask

  // wait until every result is in, then let the sequencer settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  localparam logic signed [15:0] SMax = 16'sh7FFF;
  localparam logic signed [15:0] SMin = -16'sh8000;

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero root, level and tilted poses
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 100, -100, 50, 10);
    send_sample(0, 0, 16384, 0, 0, 0, 10);
    send_sample(SMax, SMax, SMax, SMax, SMax, SMax, 16'hFFFF);
    send_sample(SMin, SMin, SMin, SMin, SMin, SMin, 16'hFFFF);
    send_sample(SMin, 0, 0, SMin, SMax, SMin, 16'hFFFF);
    send_sample(0, SMin, 0, SMax, SMin, SMax, 16'hFFFF);
    send_sample(16384, -16384, 1, -1, 1, -1, 1);
    send_sample(-1, 1, 0, 1, -1, 1, 16'h8000);
    drain();

    // zero sensitivity is treated as a sensitivity of one
    apb_write(RegSens, 16'd0);
    apb_write(RegGyroW, 16'hFFFF);
    apb_write(RegAccW, 16'hFFFF);
    send_sample(SMax, SMin, 1, SMax, SMin, SMax, 16'hFFFF);
    send_sample(SMin, SMax, -1, SMin, SMax, SMin, 16'hFFFF);
    send_sample(100, 200, 300, 5, -5, 5, 3);
    drain();
    apb_write(RegSens, 16'hFFFF);
    apb_write(RegGyroW, 16'd0);
    apb_write(RegAccW, 16'd0);
    send_sample(1000, -2000, 3000, 400, 500, -600, 20);
    send_sample(SMax, SMax, 0, SMax, SMax, SMax, 16'hFFFF);
    drain();
    apb_write(RegSens, 16'd1);
    apb_write(RegGyroW, 16'd32768);
    apb_write(RegAccW, 16'd32768);
    send_sample(-3000, 2000, -1000, -7, 9, 11, 5);
    drain();

    // random phases with changing registers and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 34; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5) begin
        apb_write(RegSens, 16'd33536);
        apb_write(RegGyroW, 16'd62915);
        apb_write(RegAccW, 16'd2621);
      end else begin
        apb_write(RegSens, 16'($urandom_range(0, 65535)));
        apb_write(RegGyroW, 16'($urandom));
        apb_write(RegAccW, 16'($urandom));
      end
      fork
        // long receiver hold-off while samples keep coming
        if (ph == 2) begin
          recv_hold = 1'b1;
          repeat (3000) @(posedge clk_i);
          recv_hold = 1'b0;
        end
        for (int n = 0; n < 240; n++) send_random();
      join
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("imu_complementary_attitude_filter_core regression: pass");
    end else begin
      $display("imu_complementary_attitude_filter_core regression: fail");
    end
    $finish;
  end

endmodule
